[hdl/asfu_pkg.sv]
// ----------------------------------------------------------------------------
// asfu_pkg
// Shared types and constants for the source function update block.
// ----------------------------------------------------------------------------
package asfu_pkg;

	typedef enum logic [1:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_DIV
	} fop_t;

	typedef struct packed {
		fop_t        op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PRE,
		F_MUL,
		F_DIV,
		F_NORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAT,
		ST_SCAT_LAM,
		ST_DENOM,
		ST_SCAT_J,
		ST_THERM,
		ST_TARGET,
		ST_DIFF,
		ST_DS,
		ST_SNEW,
		ST_REL,
		ST_OUT
	} seq_state_t;

	localparam logic [63:0] DBL_ONE       = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_FLOOR     = 64'h3D06_849B_86A1_2B9B;
	localparam logic [63:0] DBL_FLOOR_NEG = 64'hBD06_849B_86A1_2B9B;
	localparam logic [63:0] DBL_DEF_NAN   = 64'hFFF8_0000_0000_0000;
	localparam logic [62:0] DBL_INF_MAG   = 63'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_QUIET     = 64'h0008_0000_0000_0000;

endpackage

[hdl/asfu_fpu.sv]
// ----------------------------------------------------------------------------
// asfu_fpu
// Iterative binary64 add/sub/mul/div unit, round to nearest even.
// Multiply and divide run one bit per cycle; normalisation one bit per cycle.
// ----------------------------------------------------------------------------
module asfu_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  asfu_pkg::fpu_req_t req,
	output logic               done,
	output logic [63:0]        result
);
	import asfu_pkg::*;

	localparam logic signed [13:0] E_BIAS = 14'sd1023;

	fpu_state_t         fst_q, fst_d;
	fop_t               op_q;
	logic               sgn_q;
	logic signed [13:0] ea_q, eb_q, e_q;
	logic [52:0]        ma_q, mb_q;
	logic [105:0]       acc_q;
	logic [54:0]        rem_q;
	logic [6:0]         cnt_q;
	logic [63:0]        res_q;

	// operand classification
	logic [10:0] exa, exb;
	logic        sa, sb, sbe;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic        spec;
	logic [63:0] spec_val;

	// add path
	logic         a_big;
	logic [10:0]  ex_big, ex_sml, eu_big, eu_sml, dexp;
	logic [51:0]  fr_big, fr_sml;
	logic         s_big;
	logic [105:0] big_w, sml_w, sml_mask, sml_al, add_sum;

	// iteration helpers
	logic         ge;
	logic [54:0]  r2;
	logic [55:0]  q_full;
	logic [10:0]  rexp;
	logic         inc;
	logic [62:0]  rpk;

	always_comb begin
		exa    = req.a[62:52];
		exb    = req.b[62:52];
		sa     = req.a[63];
		sb     = req.b[63];
		sbe    = (req.op == FOP_SUB) ? ~sb : sb;
		a_nan  = (exa == 11'h7FF) && (req.a[51:0] != 52'd0);
		b_nan  = (exb == 11'h7FF) && (req.b[51:0] != 52'd0);
		a_inf  = (exa == 11'h7FF) && (req.a[51:0] == 52'd0);
		b_inf  = (exb == 11'h7FF) && (req.b[51:0] == 52'd0);
		a_zero = (req.a[62:0] == 63'd0);
		b_zero = (req.b[62:0] == 63'd0);

		spec     = 1'b1;
		spec_val = 64'd0;
		if (a_nan) begin
			spec_val = req.a | DBL_QUIET;
		end else if (b_nan) begin
			spec_val = req.b | DBL_QUIET;
		end else begin
			unique case (req.op)
				FOP_ADD, FOP_SUB: begin
					if (a_inf && b_inf) begin
						spec_val = (sa == sbe) ? req.a : DBL_DEF_NAN;
					end else if (a_inf) begin
						spec_val = req.a;
					end else if (b_inf) begin
						spec_val = {sbe, req.b[62:0]};
					end else if (a_zero && b_zero) begin
						spec_val = {sa & sbe, 63'd0};
					end else if (a_zero) begin
						spec_val = {sbe, req.b[62:0]};
					end else if (b_zero) begin
						spec_val = req.a;
					end else begin
						spec = 1'b0;
					end
				end
				FOP_MUL: begin
					if ((a_inf && b_zero) || (a_zero && b_inf)) begin
						spec_val = DBL_DEF_NAN;
					end else if (a_inf || b_inf) begin
						spec_val = {sa ^ sb, DBL_INF_MAG};
					end else if (a_zero || b_zero) begin
						spec_val = {sa ^ sb, 63'd0};
					end else begin
						spec = 1'b0;
					end
				end
				FOP_DIV: begin
					if ((a_zero && b_zero) || (a_inf && b_inf)) begin
						spec_val = DBL_DEF_NAN;
					end else if (a_inf || b_zero) begin
						spec_val = {sa ^ sb, DBL_INF_MAG};
					end else if (b_inf || a_zero) begin
						spec_val = {sa ^ sb, 63'd0};
					end else begin
						spec = 1'b0;
					end
				end
			endcase
		end
	end

	// alignment of the smaller addend, sticky folded into the lsb
	always_comb begin
		a_big  = req.a[62:0] >= req.b[62:0];
		ex_big = a_big ? exa : exb;
		ex_sml = a_big ? exb : exa;
		fr_big = a_big ? req.a[51:0] : req.b[51:0];
		fr_sml = a_big ? req.b[51:0] : req.a[51:0];
		s_big  = a_big ? sa : sbe;
		eu_big = (ex_big == 11'd0) ? 11'd1 : ex_big;
		eu_sml = (ex_sml == 11'd0) ? 11'd1 : ex_sml;
		dexp   = eu_big - eu_sml;
		big_w  = {1'b0, (ex_big != 11'd0), fr_big, 52'd0};
		sml_w  = {1'b0, (ex_sml != 11'd0), fr_sml, 52'd0};
		sml_mask = (106'd1 << dexp[6:0]) - 106'd1;
		if (dexp > 11'd105) begin
			sml_al = {105'd0, 1'b1};
		end else begin
			sml_al = (sml_w >> dexp[6:0]) | {105'd0, |(sml_w & sml_mask)};
		end
		add_sum = (sa ^ sbe) ? big_w - sml_al : big_w + sml_al;
	end

	always_comb begin
		ge     = rem_q >= {2'b00, mb_q};
		r2     = ge ? rem_q - {2'b00, mb_q} : rem_q;
		q_full = {acc_q[54:0], ge};
		rexp   = acc_q[104] ? e_q[10:0] : 11'd0;
		inc    = acc_q[51] & (acc_q[52] | (|acc_q[50:0]));
		rpk    = {rexp, acc_q[103:52]} + {62'd0, inc};
	end

	// next state
	always_comb begin
		fst_d = fst_q;
		unique case (fst_q)
			F_IDLE: begin
				if (start) begin
					if (spec) begin
						fst_d = F_DONE;
					end else if (req.op == FOP_ADD || req.op == FOP_SUB) begin
						fst_d = (add_sum == 106'd0) ? F_DONE : F_NORM;
					end else begin
						fst_d = F_PRE;
					end
				end
			end
			F_PRE: begin
				if (ma_q[52] && mb_q[52]) begin
					fst_d = (op_q == FOP_MUL) ? F_MUL : F_DIV;
				end
			end
			F_MUL:   if (cnt_q == 7'd1) fst_d = F_NORM;
			F_DIV:   if (cnt_q == 7'd1) fst_d = F_NORM;
			F_NORM: begin
				if (e_q >= -14'sd110 && !acc_q[105] && e_q >= 14'sd1 &&
				    (acc_q[104] || e_q <= 14'sd1)) begin
					fst_d = F_ROUND;
				end
			end
			F_ROUND: fst_d = F_DONE;
			F_DONE:  fst_d = F_IDLE;
			default: fst_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done   = (fst_q == F_DONE);
		result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
		end else begin
			fst_q <= fst_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (fst_q)
			F_IDLE: begin
				if (start) begin
					op_q <= req.op;
					if (spec) begin
						res_q <= spec_val;
					end else if (req.op == FOP_ADD || req.op == FOP_SUB) begin
						acc_q <= add_sum;
						e_q   <= $signed({3'b000, eu_big});
						sgn_q <= s_big;
						res_q <= 64'd0;
					end else begin
						sgn_q <= sa ^ sb;
						ma_q  <= {(exa != 11'd0), req.a[51:0]};
						mb_q  <= {(exb != 11'd0), req.b[51:0]};
						ea_q  <= $signed({3'b000, (exa == 11'd0) ? 11'd1 : exa});
						eb_q  <= $signed({3'b000, (exb == 11'd0) ? 11'd1 : exb});
					end
				end
			end
			F_PRE: begin
				if (!ma_q[52]) begin
					ma_q <= {ma_q[51:0], 1'b0};
					ea_q <= ea_q - 14'sd1;
				end
				if (!mb_q[52]) begin
					mb_q <= {mb_q[51:0], 1'b0};
					eb_q <= eb_q - 14'sd1;
				end
				acc_q <= 106'd0;
				rem_q <= {2'b00, ma_q};
				if (op_q == FOP_MUL) begin
					cnt_q <= 7'd53;
					e_q   <= ea_q + eb_q - E_BIAS;
				end else begin
					cnt_q <= 7'd56;
					e_q   <= ea_q - eb_q + E_BIAS;
				end
			end
			F_MUL: begin
				acc_q <= {acc_q[104:0], 1'b0} + (mb_q[52] ? {53'd0, ma_q} : 106'd0);
				mb_q  <= {mb_q[51:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
			end
			F_DIV: begin
				rem_q <= {r2[53:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					acc_q <= {1'b0, q_full, (r2 != 55'd0), 48'd0};
				end else begin
					acc_q <= {acc_q[104:0], ge};
				end
			end
			F_NORM: begin
				if (e_q < -14'sd110) begin
					acc_q <= {105'd0, |acc_q};
					e_q   <= 14'sd1;
				end else if (acc_q[105] || e_q < 14'sd1) begin
					acc_q <= {1'b0, acc_q[105:2], acc_q[1] | acc_q[0]};
					e_q   <= e_q + 14'sd1;
				end else if (!acc_q[104] && e_q > 14'sd1) begin
					acc_q <= {acc_q[104:0], 1'b0};
					e_q   <= e_q - 14'sd1;
				end
			end
			F_ROUND: begin
				if (e_q >= 14'sd2047) begin
					res_q <= {sgn_q, DBL_INF_MAG};
				end else begin
					res_q <= {sgn_q, rpk};
				end
			end
			F_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/ali_source_function_update.sv]
// ----------------------------------------------------------------------------
// ali_source_function_update
// Lambda-iteration source function update for one grid cell per transaction.
// ----------------------------------------------------------------------------
// Input stream (s_axis_*): one cell per transaction, five binary64 words in
// tdata and the end-of-sweep mark in tlast. Output stream (m_axis_*): new S,
// relative change and running maximum in tdata, end-of-sweep in tlast.
// Each cell runs as a sequence of up to ten floating-point operations (five add or
// subtract, three multiply, up to two divide) on one shared iterative unit.
// Multiply and divide produce one mantissa bit per cycle, so they dominate the
// time a cell takes, which grows when subnormals or heavy cancellation lengthen
// the one-bit-per-cycle normalisation.
// s_axis_tready is high only while the sequencer is idle; one cell at a time.
// The result sits in an output register, so the next cell is taken while a
// result still waits; a stalled receiver stops the sequencer only when it
// must load the next result.
// Reset clears the sequencer, the output valid and the running maximum (+0).
// ----------------------------------------------------------------------------
module ali_source_function_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// eps_bits, s_old_bits, j_mean_bits, planck_bits, lambda_bits
	input  logic [319:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// s_new_bits, rel_change_bits, max_rel_bits
	output logic [191:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	import asfu_pkg::*;

	seq_state_t  st_q, st_d;
	logic [63:0] eps_q, s_q, j_q, b_q, lam_q;
	logic        last_q;
	logic [63:0] scat_q, prod_q, denom_q, therm_q, diff_q, ds_q, snew_q, rel_q;
	logic [63:0] run_q;
	logic        issued_q;
	logic        m_valid_q, m_last_q;
	logic [191:0] m_data_q;

	fpu_req_t    req;
	logic        start, fdone;
	logic [63:0] fres;
	logic        is_calc, s_pos, out_free, rel_nan;
	logic [63:0] max_new, clamp_val;

	asfu_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.done   (fdone),
		.result (fres)
	);

	always_comb begin
		s_pos    = (s_q[62:0] != 63'd0) && (s_q[62:0] <= DBL_INF_MAG);
		out_free = !m_valid_q || m_axis_tready;
		rel_nan  = rel_q[62:0] > DBL_INF_MAG;
		max_new  = (!rel_nan && rel_q > run_q) ? rel_q : run_q;
		if (fres[62:0] < DBL_FLOOR[62:0]) begin
			clamp_val = (!fres[63] || fres[62:0] == 63'd0) ? DBL_FLOOR : DBL_FLOOR_NEG;
		end else begin
			clamp_val = fres;
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:     if (s_axis_tvalid) st_d = ST_SCAT;
			ST_SCAT:     if (fdone) st_d = ST_SCAT_LAM;
			ST_SCAT_LAM: if (fdone) st_d = ST_DENOM;
			ST_DENOM:    if (fdone) st_d = ST_SCAT_J;
			ST_SCAT_J:   if (fdone) st_d = ST_THERM;
			ST_THERM:    if (fdone) st_d = ST_TARGET;
			ST_TARGET:   if (fdone) st_d = ST_DIFF;
			ST_DIFF:     if (fdone) st_d = ST_DS;
			ST_DS:       if (fdone) st_d = ST_SNEW;
			ST_SNEW:     if (fdone) st_d = ST_REL;
			ST_REL:      if (fdone || !s_pos) st_d = ST_OUT;
			ST_OUT:      if (out_free) st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	// operation issue
	always_comb begin
		req.op  = FOP_ADD;
		req.a   = 64'd0;
		req.b   = 64'd0;
		is_calc = 1'b1;
		unique case (st_q)
			ST_SCAT:     begin req.op = FOP_SUB; req.a = DBL_ONE; req.b = eps_q;   end
			ST_SCAT_LAM: begin req.op = FOP_MUL; req.a = scat_q;  req.b = lam_q;   end
			ST_DENOM:    begin req.op = FOP_SUB; req.a = DBL_ONE; req.b = prod_q;  end
			ST_SCAT_J:   begin req.op = FOP_MUL; req.a = scat_q;  req.b = j_q;     end
			ST_THERM:    begin req.op = FOP_MUL; req.a = eps_q;   req.b = b_q;     end
			ST_TARGET:   begin req.op = FOP_ADD; req.a = prod_q;  req.b = therm_q; end
			ST_DIFF:     begin req.op = FOP_SUB; req.a = diff_q;  req.b = s_q;     end
			ST_DS:       begin req.op = FOP_DIV; req.a = diff_q;  req.b = denom_q; end
			ST_SNEW:     begin req.op = FOP_ADD; req.a = s_q;     req.b = ds_q;    end
			ST_REL:      begin req.op = FOP_DIV; req.a = ds_q;    req.b = s_q;     end
			ST_IDLE, ST_OUT: is_calc = 1'b0;
			default:     is_calc = 1'b0;
		endcase
		start         = is_calc && !issued_q && !(st_q == ST_REL && !s_pos);
		s_axis_tready = (st_q == ST_IDLE);
		m_axis_tvalid = m_valid_q;
		m_axis_tdata  = m_data_q;
		m_axis_tlast  = m_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			issued_q  <= 1'b0;
			m_valid_q <= 1'b0;
			run_q     <= 64'd0;
		end else begin
			st_q <= st_d;
			if (fdone) begin
				issued_q <= 1'b0;
			end else if (start) begin
				issued_q <= 1'b1;
			end
			if (st_q == ST_OUT && out_free) begin
				m_valid_q <= 1'b1;
				run_q     <= last_q ? 64'd0 : max_new;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			eps_q  <= s_axis_tdata[63:0];
			s_q    <= s_axis_tdata[127:64];
			j_q    <= s_axis_tdata[191:128];
			b_q    <= s_axis_tdata[255:192];
			lam_q  <= s_axis_tdata[319:256];
			last_q <= s_axis_tlast;
		end
		if (fdone) begin
			unique case (st_q)
				ST_SCAT:     scat_q  <= fres;
				ST_SCAT_LAM: prod_q  <= fres;
				ST_DENOM:    denom_q <= clamp_val;
				ST_SCAT_J:   prod_q  <= fres;
				ST_THERM:    therm_q <= fres;
				ST_TARGET:   diff_q  <= fres;
				ST_DIFF:     diff_q  <= fres;
				ST_DS:       ds_q    <= fres;
				ST_SNEW:     snew_q  <= fres;
				ST_REL:      rel_q   <= {1'b0, fres[62:0]};
				default:     begin end
			endcase
		end else if (st_q == ST_REL && !s_pos) begin
			rel_q <= {1'b0, ds_q[62:0]};
		end
		if (st_q == ST_OUT && out_free) begin
			m_data_q <= {max_new, rel_q, snew_q};
			m_last_q <= last_q;
		end
	end

endmodule

[hdl/asfu_checker.sv]
// ----------------------------------------------------------------------------
// asfu_checker
// Port-level checks on the source function update block, bound to its top.
// ----------------------------------------------------------------------------
module asfu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [191:0] m_axis_tdata,
	input logic         m_axis_tlast
);

	// one cell at a time: an accepted transaction closes the input
	a_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again straight after a transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// maximum and relative change carry no sign
	a_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[127] && !m_axis_tdata[191])
		else $error("sign set on relative change or maximum");

	// running maximum covers this cell unless its change is NaN
	a_max_cover: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[126:64] <= 63'h7FF0_0000_0000_0000 |->
		m_axis_tdata[190:128] >= m_axis_tdata[126:64])
		else $error("maximum below this cell's change");

endmodule

bind ali_source_function_update asfu_checker u_asfu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
